[hw/rtl/spc_pkg.sv]
// Shared constants, request codes and controller/datapath interface types.
`default_nettype none

package spc_pkg;

    // Pixel memory geometry; request addresses wrap inside it.
    localparam int PIXEL_WORDS = 4096;
    localparam int PIX_ADDR_W  = 12;

    // Stream widths.
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 24;

    // Request kinds carried on s_tuser.
    localparam logic [1:0] OP_SPRITE = 2'd0;
    localparam logic [1:0] OP_PIXEL  = 2'd1;
    localparam logic [1:0] OP_RENDER = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_IDX_W        = 2;
    localparam logic [1:0] CFG_BACKGROUND   = 2'd0;
    localparam logic [1:0] CFG_SCREEN_WIDTH = 2'd1;

    localparam logic [15:0] BG_RESET    = 16'hF00F;
    localparam logic [9:0]  WIDTH_RESET = 10'd320;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic calc_hit;
        logic pick;
        logic calc_mul;
        logic mem_rd;
        logic out_load;
    } spc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } spc_status_t;

endpackage

`default_nettype wire

[hw/rtl/spc_datapath.sv]
// Datapath: sprite table, hit compare, depth pick, address multiply, pixel memory, output register.
`default_nettype none

module spc_datapath #(
    parameter int SPRITE_SLOTS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [spc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [15:0]                         cfg_wr_data,
    input  logic [1:0]                          s_tuser,
    input  logic [spc_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  spc_pkg::spc_cmd_t                   cmd,
    output spc_pkg::spc_status_t                status,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [spc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser
);
    import spc_pkg::*;

    localparam int SLOT_W = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;

    // Request fields.
    logic [2:0]  in_slot;
    logic [8:0]  in_x;
    logic [8:0]  in_y;
    logic [9:0]  in_w;
    logic [9:0]  in_h;
    logic [7:0]  in_z;
    logic [11:0] in_addr;
    logic [15:0] in_pixel;

    assign in_slot  = s_tdata[2:0];
    assign in_x     = s_tdata[11:3];
    assign in_y     = s_tdata[20:12];
    assign in_w     = s_tdata[30:21];
    assign in_h     = s_tdata[40:31];
    assign in_z     = s_tdata[48:41];
    assign in_addr  = s_tdata[60:49];
    assign in_pixel = s_tdata[76:61];

    // Configuration.
    logic [15:0] bg_reg;
    logic [9:0]  width_reg;

    // Sprite table.
    logic [SPRITE_SLOTS-1:0] valid_reg;
    logic [8:0]  spr_x_reg [SPRITE_SLOTS];
    logic [8:0]  spr_y_reg [SPRITE_SLOTS];
    logic [9:0]  spr_w_reg [SPRITE_SLOTS];
    logic [9:0]  spr_h_reg [SPRITE_SLOTS];
    logic [7:0]  spr_z_reg [SPRITE_SLOTS];
    logic [11:0] spr_base_reg [SPRITE_SLOTS];

    // Pixel memory.
    logic [15:0] pix_mem [PIXEL_WORDS];
    logic [15:0] rd_data_reg;

    // Render pipeline registers.
    logic [8:0]              px_reg;
    logic [8:0]              py_reg;
    logic [SPRITE_SLOTS-1:0] hit_reg;
    logic [SPRITE_SLOTS-1:0] hit_next;
    logic                    found_reg;
    logic                    found_next;
    logic [SLOT_W-1:0]       win_reg;
    logic [SLOT_W-1:0]       win_next;
    logic [18:0]             prod_reg;
    logic [18:0]             prod_next;
    logic [8:0]              dx_reg;
    logic [8:0]              dx_next;
    logic [11:0]             base_reg;
    logic [PIX_ADDR_W-1:0]   rd_addr;

    // Output register.
    logic        out_valid_reg;
    logic [15:0] out_color_reg;
    logic        out_cov_reg;
    logic [2:0]  out_slot_reg;
    logic [6:0]  win_wide;

    logic wr_desc;
    logic wr_pixel;
    logic in_screen;

    assign wr_desc   = cmd.accept && (s_tuser == OP_SPRITE);
    assign wr_pixel  = cmd.accept && (s_tuser == OP_PIXEL);
    assign in_screen = {1'b0, px_reg} < width_reg;

    // Per-slot coverage test.
    always_comb begin
        for (int i = 0; i < SPRITE_SLOTS; i++) begin
            hit_next[i] = valid_reg[i]
                && (spr_x_reg[i] <= px_reg)
                && ({2'b00, px_reg} < ({2'b00, spr_x_reg[i]} + {1'b0, spr_w_reg[i]}))
                && (spr_y_reg[i] <= py_reg)
                && ({2'b00, py_reg} < ({2'b00, spr_y_reg[i]} + {1'b0, spr_h_reg[i]}));
        end
    end

    // Depth pick: the last covering slot with depth at or above the best wins.
    always_comb begin
        logic       found_c;
        logic [7:0] best_c;
        found_c  = 1'b0;
        best_c   = '0;
        win_next = '0;
        for (int i = 0; i < SPRITE_SLOTS; i++) begin
            if (hit_reg[i] && (!found_c || (spr_z_reg[i] >= best_c))) begin
                found_c  = 1'b1;
                best_c   = spr_z_reg[i];
                win_next = SLOT_W'(i);
            end
        end
        found_next = found_c && in_screen;
    end

    // Row offset times width, and column offset, of the winning sprite.
    always_comb begin
        logic [8:0] dy;
        dy        = py_reg - spr_y_reg[win_reg];
        dx_next   = px_reg - spr_x_reg[win_reg];
        prod_next = {10'b0, dy} * {9'b0, spr_w_reg[win_reg]};
    end

    assign rd_addr = base_reg + prod_reg[PIX_ADDR_W-1:0] + {3'b000, dx_reg};

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_reg        <= BG_RESET;
            width_reg     <= WIDTH_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_BACKGROUND:   bg_reg    <= cfg_wr_data;
                    CFG_SCREEN_WIDTH: width_reg <= cfg_wr_data[9:0];
                    default: ;
                endcase
            end
            for (int i = 0; i < SPRITE_SLOTS; i++) begin
                if (wr_desc && (7'(in_slot) == 7'(i))) begin
                    valid_reg[i] <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < SPRITE_SLOTS; i++) begin
            if (wr_desc && (7'(in_slot) == 7'(i))) begin
                spr_x_reg[i]    <= in_x;
                spr_y_reg[i]    <= in_y;
                spr_w_reg[i]    <= in_w;
                spr_h_reg[i]    <= in_h;
                spr_z_reg[i]    <= in_z;
                spr_base_reg[i] <= in_addr;
            end
        end
        if (cmd.accept) begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (cmd.calc_hit) begin
            hit_reg <= hit_next;
        end
        if (cmd.pick) begin
            found_reg <= found_next;
            win_reg   <= win_next;
        end
        if (cmd.calc_mul) begin
            prod_reg <= prod_next;
            dx_reg   <= dx_next;
            base_reg <= spr_base_reg[win_reg];
        end
        if (cmd.out_load) begin
            out_color_reg <= found_reg ? rd_data_reg : bg_reg;
            out_cov_reg   <= found_reg;
            out_slot_reg  <= found_reg ? win_wide[2:0] : 3'b000;
        end
    end

    assign win_wide = 7'(win_reg);

    // Pixel memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_pixel) begin
            pix_mem[in_addr] <= in_pixel;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= pix_mem[rd_addr];
        end
    end

    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {5'b00000, out_slot_reg, out_color_reg};
    assign m_tuser         = out_cov_reg;

`ifndef ASSERT_OFF
    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(cmd.out_load))
        else $error("result appeared without an output load");
    a_bg_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_cov_reg) |-> (out_slot_reg == 3'b000))
        else $error("background result carries a nonzero slot");
    a_found_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.calc_mul && found_reg) |-> in_screen)
        else $error("sprite found for an off-screen column");
`endif

endmodule

`default_nettype wire

[hw/rtl/spc_ctrl.sv]
// Controller: sequences request acceptance and the render steps of the datapath.
`default_nettype none

module spc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic [1:0]            s_opcode,
    output logic                  s_tready,
    input  spc_pkg::spc_status_t  status,
    output spc_pkg::spc_cmd_t     cmd
);
    import spc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIT,
        ST_PICK,
        ST_MUL,
        ST_READ,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && (s_opcode == OP_RENDER)) begin
                    state_next = ST_HIT;
                end
            end
            ST_HIT: begin
                cmd.calc_hit = 1'b1;
                state_next   = ST_PICK;
            end
            ST_PICK: begin
                cmd.pick   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.calc_mul = 1'b1;
                state_next   = ST_READ;
            end
            ST_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !status.out_busy)
        else $error("output loaded over an untaken result");
    a_render_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && (s_opcode == OP_RENDER)) |=> !s_tready)
        else $error("new request taken while a render is in flight");
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.calc_hit, cmd.pick, cmd.calc_mul, cmd.mem_rd,
                  cmd.out_load}))
        else $error("more than one datapath step commanded");
`endif

endmodule

`default_nettype wire

[hw/rtl/sprite_priority_compositor.sv]
// Top level of the sprite compositor: controller plus datapath.
//
//  Channel   Direction  Handshake                  Payload
//  s_        in         s_tvalid / s_tready        s_tuser opcode, s_tdata sprite/pixel/render
//  m_        out        m_tvalid / m_tready        m_tuser covered, m_tdata color and slot
//  cfg_      in         cfg_wr_en (always taken)   cfg_addr index, cfg_wr_data value
//
// A sprite load or pixel write leaves the block idle and ready again in the next cycle.
// A render request is accepted and then walks through four internal steps (per-slot hit
// compare, depth pick, address multiply, pixel memory read) before the result is loaded
// into the output register, so a render holds off the input until its result is loaded.
// The output register frees the input side: a new request is taken while a result still
// waits for m_tready; a render only stalls in its last step if the previous result is
// still held. Reset is synchronous on aresetn low and clears the sprite valid marks at
// once; no clearing pass is needed.
`default_nettype none

module sprite_priority_compositor #(
    parameter int SPRITE_SLOTS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration writes: 0 background_color, 1 screen_width.
    input  logic                               cfg_wr_en,
    input  logic [spc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [15:0]                        cfg_wr_data,
    // Requests.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tuser: opcode[1:0]
    input  logic [1:0]                         s_tuser,
    // s_tdata from bit 0: slot[2:0], pos_x[11:3], pos_y[20:12], size_w[30:21],
    // size_h[40:31], depth_z[48:41], mem_addr[60:49], pixel_value[76:61], zero[79:77]
    input  logic [spc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Results.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tuser: covered[0]
    output logic                               m_tuser,
    // m_tdata from bit 0: pixel_color[15:0], top_slot[18:16], zero[23:19]
    output logic [spc_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import spc_pkg::*;

    spc_cmd_t    cmd;
    spc_status_t status;

    spc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_opcode (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spc_datapath #(
        .SPRITE_SLOTS (SPRITE_SLOTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

[dv/sprite_priority_compositor_test.sv]
// Self-checking testbench for the sprite priority compositor stream block.
`default_nettype none

module sprite_priority_compositor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    localparam int SLOTS        = 8;
    // Opcode 3 is not a request kind; the block must drop it silently.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Cycles left for the block to finish work that yields no result.
    localparam int DRAIN_CYCLES = 12;
    // Worst case is a few thousand requests, each held up by random stalls, so this
    // bound leaves a wide margin.
    localparam int LIMIT_CYCLES = 500000;
    localparam int SEG_ITEMS    = 270;

    // One input request, split into its fields at the widths of the block.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  slot;
        logic [8:0]  pos_x;
        logic [8:0]  pos_y;
        logic [9:0]  size_w;
        logic [9:0]  size_h;
        logic [7:0]  depth_z;
        logic [11:0] mem_addr;
        logic [15:0] pixel_value;
    } spc_req_t;

    typedef struct packed {
        logic [8:0]  x;
        logic [8:0]  y;
        logic [9:0]  w;
        logic [9:0]  h;
        logic [7:0]  z;
        logic [11:0] base;
    } sprite_t;

    // One rendered pixel as the block should report it.
    typedef struct packed {
        logic [15:0] color;
        logic        covered;
        logic [2:0]  slot;
    } pixel_t;

    // The scoreboard keeps its own copy of the sprite table, the pixel memory and
    // the two registers, and turns every accepted render into an expected pixel.
    class pixel_scoreboard;
        logic [15:0] bg_color;
        logic [9:0]  scr_width;
        bit          sp_valid[SLOTS];
        sprite_t     sprites[SLOTS];
        logic [15:0] pix_mem[PIXEL_WORDS];
        bit          pix_written[PIXEL_WORDS];
        pixel_t      pending[$];
        int          errors;

        function new();
            bg_color  = BG_RESET;
            scr_width = WIDTH_RESET;
            foreach (sp_valid[i]) sp_valid[i] = 1'b0;
            foreach (pix_written[i]) pix_written[i] = 1'b0;
            errors = 0;
        endfunction

        function void set_cfg(logic [1:0] idx, logic [15:0] value);
            if (idx == CFG_BACKGROUND)
                bg_color = value;
            else if (idx == CFG_SCREEN_WIDTH)
                scr_width = value[9:0];
        endfunction

        // Finds the sprite that supplies a screen pixel and the word it reads.
        // The highest depth wins; on equal depth the later (higher) slot wins.
        function bit locate(input int unsigned px, input int unsigned py,
                            output int win, output logic [11:0] addr);
            bit          found;
            int unsigned best_z;
            int unsigned x_end;
            int unsigned y_end;
            int unsigned offs;
            found  = 1'b0;
            best_z = 0;
            win    = 0;
            addr   = '0;
            if (px < scr_width) begin
                for (int i = 0; i < SLOTS; i++) begin
                    x_end = 32'(sprites[i].x) + 32'(sprites[i].w);
                    y_end = 32'(sprites[i].y) + 32'(sprites[i].h);
                    if (sp_valid[i] && sprites[i].x <= px && px < x_end &&
                        sprites[i].y <= py && py < y_end &&
                        (!found || sprites[i].z >= best_z)) begin
                        found  = 1'b1;
                        best_z = 32'(sprites[i].z);
                        win    = i;
                    end
                end
            end
            if (found) begin
                offs = sprites[win].base + (py - sprites[win].y) * sprites[win].w
                       + (px - sprites[win].x);
                addr = 12'(offs % PIXEL_WORDS);
            end else begin
                win = 0;
            end
            return found;
        endfunction

        function void note(spc_req_t r);
            int          win;
            logic [11:0] addr;
            pixel_t      pix;
            case (r.opcode)
                OP_SPRITE: begin
                    sprites[r.slot] = '{r.pos_x, r.pos_y, r.size_w, r.size_h,
                                        r.depth_z, r.mem_addr};
                    sp_valid[r.slot] = 1'b1;
                end
                OP_PIXEL: begin
                    pix_mem[r.mem_addr]     = r.pixel_value;
                    pix_written[r.mem_addr] = 1'b1;
                end
                OP_RENDER: begin
                    if (locate(32'(r.pos_x), 32'(r.pos_y), win, addr))
                        pix = '{pix_mem[addr], 1'b1, win[2:0]};
                    else
                        pix = '{bg_color, 1'b0, 3'd0};
                    pending = {pending, pix};
                end
                default: ;
            endcase
        endfunction

        task report(string what, logic [15:0] want, logic [15:0] got);
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
            errors++;
        endtask

        task check(logic [15:0] color, logic covered, logic [2:0] slot);
            pixel_t want;
            if (pending.size() == 0) begin
                report("unrequested result (color)", 16'd0, color);
            end else begin
                want = pending.pop_front();
                if (color !== want.color) report("pixel_color", want.color, color);
                if (covered !== want.covered)
                    report("covered", 16'(want.covered), 16'(covered));
                if (slot !== want.slot) report("top_slot", 16'(want.slot), 16'(slot));
            end
        endtask
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_addr    = '0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser     = '0;
    logic [79:0] s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic        m_tuser;
    logic [23:0] m_tdata;

    int send_idle_pct = 34;
    int recv_idle_pct = 53;
    int cycle_count   = 0;

    pixel_scoreboard sb;

    sprite_priority_compositor #(
        .SPRITE_SLOTS(SLOTS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // The result side stalls at random; the main process sets how often.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every result taken at an edge is held against the oldest expected pixel.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check(m_tdata[15:0], m_tuser, m_tdata[18:16]);
    end

    // Watchdog: a hung block or a lost result ends the run here.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Fills every field at random so that unused fields carry noise too.
    function automatic spc_req_t random_req();
        spc_req_t r;
        r.opcode      = 2'($urandom);
        r.slot        = 3'($urandom);
        r.pos_x       = 9'($urandom);
        r.pos_y       = 9'($urandom);
        r.size_w      = 10'($urandom);
        r.size_h      = 10'($urandom);
        r.depth_z     = 8'($urandom);
        r.mem_addr    = 12'($urandom);
        r.pixel_value = 16'($urandom);
        return r;
    endfunction

    // Presents one request and holds it until the block takes it. Valid stays up
    // afterwards; the next request or an idle cycle decides what comes next.
    task automatic send(spc_req_t r);
        s_tvalid <= 1'b1;
        s_tuser  <= r.opcode;
        s_tdata  <= {3'b000, r.pixel_value, r.mem_addr, r.depth_z, r.size_h,
                     r.size_w, r.pos_y, r.pos_x, r.slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note(r);
    endtask

    task automatic idle_sender();
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic load_sprite(logic [2:0] slot, logic [8:0] x, logic [8:0] y,
                               logic [9:0] w, logic [9:0] h, logic [7:0] z,
                               logic [11:0] base);
        spc_req_t r;
        r          = random_req();
        r.opcode   = OP_SPRITE;
        r.slot     = slot;
        r.pos_x    = x;
        r.pos_y    = y;
        r.size_w   = w;
        r.size_h   = h;
        r.depth_z  = z;
        r.mem_addr = base;
        send(r);
    endtask

    task automatic write_pixel(logic [11:0] addr, logic [15:0] value);
        spc_req_t r;
        r             = random_req();
        r.opcode      = OP_PIXEL;
        r.mem_addr    = addr;
        r.pixel_value = value;
        send(r);
    endtask

    // A render must never read a pixel word that was not written, so the word it
    // will read is filled first when the scoreboard has no record of it.
    task automatic render(logic [8:0] px, logic [8:0] py);
        spc_req_t    r;
        int          win;
        logic [11:0] addr;
        if (sb.locate(32'(px), 32'(py), win, addr) && !sb.pix_written[addr]) begin
            write_pixel(addr, 16'($urandom));
            idle_sender();
        end
        r        = random_req();
        r.opcode = OP_RENDER;
        r.pos_x  = px;
        r.pos_y  = py;
        send(r);
    endtask

    // Registers change only while the block is idle; the scoreboard follows.
    task automatic write_cfg(logic [1:0] idx, logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_cfg(idx, value);
        @(posedge aclk);
    endtask

    // Waits until every expected pixel has come back, then lets loads settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Random traffic. Sprites are mostly small and often near the origin so that they
    // overlap, depths often collide so that slot order decides, and most renders
    // aim inside a loaded sprite.
    task automatic run_random(int count);
        int          pick;
        int          sel;
        int          s;
        int unsigned hi;
        logic [8:0]  px;
        logic [8:0]  py;
        logic [9:0]  w;
        logic [9:0]  h;
        spc_req_t    r;
        repeat (count) begin
            idle_sender();
            pick = $urandom_range(99);
            if (pick < 15) begin
                sel = $urandom_range(99);
                if (sel < 70) begin
                    w = 10'($urandom_range(32, 1));
                    h = 10'($urandom_range(32, 1));
                end else if (sel < 85) begin
                    w = 10'($urandom_range(1023, 0));
                    h = 10'($urandom_range(1023, 0));
                end else if (sel < 93) begin
                    w = ($urandom_range(1) != 0) ? 10'd0 : 10'($urandom_range(32, 1));
                    h = (w != 0) ? 10'd0 : 10'($urandom_range(32, 1));
                end else begin
                    w = 10'($urandom_range(1023, 512));
                    h = 10'($urandom_range(1023, 512));
                end
                load_sprite(3'($urandom),
                            9'(($urandom_range(1) != 0) ? $urandom_range(63) : $urandom),
                            9'(($urandom_range(1) != 0) ? $urandom_range(63) : $urandom),
                            w, h,
                            8'(($urandom_range(1) != 0) ? $urandom_range(3) : $urandom),
                            12'($urandom));
            end else if (pick < 35) begin
                write_pixel(12'($urandom), 16'($urandom));
            end else if (pick < 95) begin
                s = $urandom_range(SLOTS - 1);
                if ($urandom_range(99) < 75 && sb.sp_valid[s] &&
                    sb.sprites[s].w != 0 && sb.sprites[s].h != 0) begin
                    hi = sb.sprites[s].x + sb.sprites[s].w - 1;
                    if (hi > 511) hi = 511;
                    px = 9'($urandom_range(hi, sb.sprites[s].x));
                    hi = sb.sprites[s].y + sb.sprites[s].h - 1;
                    if (hi > 511) hi = 511;
                    py = 9'($urandom_range(hi, sb.sprites[s].y));
                end else if ($urandom_range(1) != 0) begin
                    px = 9'($urandom_range(63));
                    py = 9'($urandom_range(63));
                end else begin
                    px = 9'($urandom);
                    py = 9'($urandom);
                end
                render(px, py);
            end else begin
                r        = random_req();
                r.opcode = OP_UNUSED;
                send(r);
            end
        end
    endtask

    initial begin
        spc_req_t    junk;
        logic [15:0] seg_bg[6];
        logic [15:0] seg_width[6];

        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, under the reset values of both registers.
        render(9'd0, 9'd0);                     // empty table gives background
        write_pixel(12'd0, 16'h0000);
        write_pixel(12'd4095, 16'hFFFF);
        load_sprite(3'd0, 9'd0, 9'd0, 10'd4, 10'd4, 8'd0, 12'd0);
        render(9'd0, 9'd0);
        // Far corner with the largest sizes, depth and base.
        load_sprite(3'd7, 9'd511, 9'd511, 10'd1023, 10'd1023, 8'd255, 12'd4095);
        render(9'd511, 9'd511);
        // Two overlapping sprites of equal depth: the higher slot must win.
        load_sprite(3'd1, 9'd2, 9'd2, 10'd4, 10'd4, 8'd9, 12'd100);
        load_sprite(3'd2, 9'd3, 9'd3, 10'd4, 10'd4, 8'd9, 12'd200);
        render(9'd3, 9'd3);
        // Sprites with zero width or zero height cover nothing despite top depth.
        load_sprite(3'd3, 9'd0, 9'd0, 10'd0, 10'd5, 8'd255, 12'd300);
        load_sprite(3'd5, 9'd0, 9'd0, 10'd5, 10'd0, 8'd255, 12'd400);
        render(9'd1, 9'd1);
        // The pixel address runs past the top of memory and wraps to the bottom.
        load_sprite(3'd4, 9'd10, 9'd10, 10'd8, 10'd8, 8'd200, 12'd4095);
        render(9'd12, 9'd11);
        render(9'd320, 9'd0);                   // first column beyond the screen
        junk        = '1;                        // unused opcode, every bit set
        junk.opcode = OP_UNUSED;
        send(junk);
        render(9'd319, 9'd3);
        drain();

        write_cfg(CFG_SCREEN_WIDTH, 16'd0);     // zero width: all background
        render(9'd0, 9'd0);
        render(9'd3, 9'd3);
        drain();
        write_cfg(CFG_BACKGROUND, 16'h0000);
        write_cfg(CFG_SCREEN_WIDTH, 16'hA800 | 16'd512);  // upper bits are dropped
        render(9'd511, 9'd511);
        render(9'd0, 9'd0);
        render(9'd511, 9'd0);
        drain();

        // Random part in six settings, with three idle profiles.
        seg_bg    = '{16'($urandom), 16'hFFFF, 16'($urandom), 16'h0000,
                      16'($urandom), BG_RESET};
        seg_width = '{16'd512, 16'd1, 16'd1023, 16'd200, 16'd64, 16'(WIDTH_RESET)};
        for (int seg = 0; seg < 6; seg++) begin
            if (seg < 2) begin
                send_idle_pct = 34;
                recv_idle_pct = 53;
            end else if (seg < 4) begin
                send_idle_pct = 53;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_cfg(CFG_BACKGROUND, seg_bg[seg]);
            write_cfg(CFG_SCREEN_WIDTH, seg_width[seg]);
            run_random(SEG_ITEMS);
            drain();
        end

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
